FILE: sv/bhm_pkg.sv
`default_nettype none

package bhm_pkg;

  localparam int CountWidth    = 16;
  localparam int MaxCountWidth = 16;
  localparam int NumSymbols    = 256;
  localparam int NumSegs       = 4;
  localparam int SegSize       = NumSymbols / NumSegs;
  localparam int SymWidth      = $clog2(NumSymbols);
  localparam int SegIdxWidth   = $clog2(NumSegs);
  localparam int SegOffWidth   = $clog2(SegSize);

  localparam logic [CountWidth-1:0]    CountLimit = '1;
  localparam logic [MaxCountWidth-1:0] MaxCountTop = '1;

  localparam logic OpCount  = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: sv/bhm_if.sv
`default_nettype none

interface bhm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bhm_pkg::SymWidth-1:0]  byte_value;

  modport source (output valid, output op, output byte_value, input ready);
  modport sink   (input valid, input op, input byte_value, output ready);
endinterface

interface bhm_out_if;
  logic                               valid;
  logic                               ready;
  logic [bhm_pkg::SegIdxWidth-1:0]    segment;
  logic [bhm_pkg::SegSize-1:0]        tie_mask;
  logic [bhm_pkg::MaxCountWidth-1:0]  max_count;
  logic                               empty_text;
  logic                               saturated;
  logic                               last;

  modport source (output valid, output segment, output tie_mask, output max_count,
                  output empty_text, output saturated, output last, input ready);
  modport sink   (input valid, input segment, input tie_mask, input max_count,
                  input empty_text, input saturated, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/byte_histogram_mode_finder_top.sv
// byte histogram mode finder
// in_ch: valid/ready beats of {op, byte_value}. op count adds byte_value to a
//   256-entry histogram of saturating counters; op finish closes the text.
// out_ch: valid/ready beats of {segment, tie_mask, max_count, empty_text,
//   saturated, last}. a finish yields four beats, segments 0..3, last on 3.
// a count beat is one registered histogram read, then the incremented
//   write; in_ch.ready is low during the write cycle.
// a finish walks the histogram one entry at a time, a read state then a
//   compare state, so each 64-entry segment is scanned before its beat is
//   offered, and the whole finish also waits on the out_ch handshakes. the
//   histogram memory port and the single compare unit set this pace.
// in_ch.ready stays low from a finish until its last beat is taken.
// a stalled out_ch holds the beat steady and halts the scan.
// per-entry valid bits, the running maximum and the saturation flag are
//   cleared at reset (rst_n low, synchronous) and with the last beat of a
//   finish, so no clearing pass is needed and the block is ready at once.
`default_nettype none

module byte_histogram_mode_finder_top (
  input  wire       clk,
  input  wire       rst_n,
  bhm_in_if.sink    in_ch,
  bhm_out_if.source out_ch
);

  bhm_pkg::state_t state_r, state_nxt;

  logic [bhm_pkg::CountWidth-1:0] hist_mem [bhm_pkg::NumSymbols];
  logic [bhm_pkg::CountWidth-1:0] hist_rd_r;
  logic [bhm_pkg::NumSymbols-1:0] vld_r;
  logic                           vld_rd_r;

  logic [bhm_pkg::SymWidth-1:0]   addr_r;
  logic [bhm_pkg::SymWidth-1:0]   rd_addr;
  logic [bhm_pkg::CountWidth-1:0] rmax_r;
  logic                           sat_r;
  logic [bhm_pkg::SegSize-1:0]    mask_r;

  logic                           in_fire;
  logic                           out_fire;
  logic                           mem_we;
  logic                           last_seg;
  logic                           seg_end;
  logic                           empty;
  logic                           hit;
  logic [bhm_pkg::CountWidth-1:0] cnt_cur;
  logic [bhm_pkg::CountWidth-1:0] cnt_inc;
  logic [31:0]                    rmax_ext;

  // datapath helpers
  assign cnt_cur  = vld_rd_r ? hist_rd_r : '0;
  assign cnt_inc  = (cnt_cur == bhm_pkg::CountLimit) ? bhm_pkg::CountLimit
                    : bhm_pkg::CountWidth'(cnt_cur + 1'b1);
  assign empty    = (rmax_r == '0);
  assign hit      = !empty && (cnt_cur == rmax_r);
  assign last_seg = (addr_r[bhm_pkg::SymWidth-1 -: bhm_pkg::SegIdxWidth]
                     == bhm_pkg::SegIdxWidth'(bhm_pkg::NumSegs - 1));
  assign seg_end  = (addr_r[bhm_pkg::SegOffWidth-1:0] == '1);
  assign rmax_ext = 32'(rmax_r);

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bhm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.op == bhm_pkg::OpFinish) ? bhm_pkg::ST_SCAN_RD
                                                      : bhm_pkg::ST_INC;
        end
      end
      bhm_pkg::ST_INC:      state_nxt = bhm_pkg::ST_IDLE;
      bhm_pkg::ST_SCAN_RD:  state_nxt = bhm_pkg::ST_SCAN_CMP;
      bhm_pkg::ST_SCAN_CMP: state_nxt = seg_end ? bhm_pkg::ST_EMIT : bhm_pkg::ST_SCAN_RD;
      bhm_pkg::ST_EMIT: begin
        if (out_fire) begin
          state_nxt = last_seg ? bhm_pkg::ST_IDLE : bhm_pkg::ST_SCAN_RD;
        end
      end
      default:              state_nxt = bhm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready       = (state_r == bhm_pkg::ST_IDLE);
    out_ch.valid      = (state_r == bhm_pkg::ST_EMIT);
    mem_we            = (state_r == bhm_pkg::ST_INC);
    rd_addr           = (state_r == bhm_pkg::ST_IDLE) ? in_ch.byte_value : addr_r;
    out_ch.segment    = addr_r[bhm_pkg::SymWidth-1 -: bhm_pkg::SegIdxWidth];
    out_ch.tie_mask   = mask_r;
    out_ch.max_count  = (rmax_ext > 32'(bhm_pkg::MaxCountTop)) ? bhm_pkg::MaxCountTop
                        : rmax_ext[bhm_pkg::MaxCountWidth-1:0];
    out_ch.empty_text = empty;
    out_ch.saturated  = sat_r;
    out_ch.last       = last_seg;
  end

  // histogram memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[addr_r] <= cnt_inc;
    end
    hist_rd_r <= hist_mem[rd_addr];
    vld_rd_r  <= vld_r[rd_addr];
  end

  // control and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhm_pkg::ST_IDLE;
      vld_r   <= '0;
      rmax_r  <= '0;
      sat_r   <= 1'b0;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        bhm_pkg::ST_IDLE: begin
          if (in_fire) begin
            addr_r <= (in_ch.op == bhm_pkg::OpFinish) ? '0 : in_ch.byte_value;
          end
        end
        bhm_pkg::ST_INC: begin
          vld_r[addr_r] <= 1'b1;
          if (cnt_inc == bhm_pkg::CountLimit) begin
            sat_r <= 1'b1;
          end
          if (cnt_inc > rmax_r) begin
            rmax_r <= cnt_inc;
          end
        end
        bhm_pkg::ST_SCAN_CMP: begin
          if (!seg_end) begin
            addr_r <= addr_r + 1'b1;
          end
        end
        bhm_pkg::ST_EMIT: begin
          if (out_fire) begin
            addr_r <= addr_r + 1'b1;
            if (last_seg) begin
              vld_r  <= '0;
              rmax_r <= '0;
              sat_r  <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tie mask shift, lowest byte value ends in bit 0
  always_ff @(posedge clk) begin
    if (state_r == bhm_pkg::ST_SCAN_CMP) begin
      mask_r <= {hit, mask_r[bhm_pkg::SegSize-1:1]};
    end
  end

  a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.op == bhm_pkg::OpCount) |=> !in_ch.ready)
    else $error("count beat did not block the input for its write cycle");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_ch.last) |=> (rmax_r == '0 && !sat_r && vld_r == '0))
    else $error("store not cleared after last beat");

  a_seg_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_ch.last) |=>
      (out_ch.segment == bhm_pkg::SegIdxWidth'($past(out_ch.segment) + 1'b1)))
    else $error("segment did not advance");

  a_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.empty_text) |-> (out_ch.tie_mask == '0))
    else $error("empty text with non-zero tie mask");

endmodule

`default_nettype wire
